// ===== sv/scc_pkg.sv =====
// shared types, constants and functions of the scene classifier
`default_nettype none
package scc_pkg;

   localparam int COUNT_BITS = 22;
   localparam int LABEL_BITS = 8;
   localparam int RATIO_BITS = 16;
   localparam int STEP_BITS  = $clog2(COUNT_BITS);
   localparam int FIVE_BITS  = 3;

   localparam logic [RATIO_BITS-1:0] RATIO_RESET = RATIO_BITS'(10);
   localparam logic [FIVE_BITS-1:0]  ROAD_SHARE  = FIVE_BITS'(5);
   localparam logic [STEP_BITS-1:0]  STEP_LAST   = STEP_BITS'(COUNT_BITS - 1);

   typedef logic [COUNT_BITS-1:0] count_type;

   typedef enum logic [1:0] {
      SCENE_CAR     = 2'd0,
      SCENE_PEOPLE  = 2'd1,
      SCENE_ROAD    = 2'd2,
      SCENE_UNKNOWN = 2'd3
   } scene_type;

   typedef enum logic [1:0] {
      CLS_OTHER,
      CLS_ROAD,
      CLS_VEHICLE,
      CLS_PERSON
   } class_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_DIVIDE,
      BACK_DECIDE
   } back_state_type;

   typedef struct packed {
      count_type pixel;
      count_type road;
      count_type vehicle;
      count_type person;
   } frame_type;

   function automatic class_type classify(input logic [LABEL_BITS-1:0] label);
      class_type cls;
      case (label) inside
         8'd0:                      cls = CLS_ROAD;
         8'd13, 8'd14, 8'd15, 8'd17: cls = CLS_VEHICLE;
         8'd11, 8'd12, 8'd18:        cls = CLS_PERSON;
         default:                   cls = CLS_OTHER;
      endcase
      return cls;
   endfunction

   function automatic count_type sat_inc(input count_type v);
      return (&v) ? v : v + count_type'(1);
   endfunction

endpackage
`default_nettype wire

// ===== sv/scc_req_if.sv =====
// pixel label channel
`default_nettype none
interface scc_req_if;
   logic                              valid;
   logic                              ready;
   logic [scc_pkg::LABEL_BITS-1:0]    label;
   logic                              last_pixel;

   modport source (output valid, output label, output last_pixel, input ready);
   modport sink   (input valid, input label, input last_pixel, output ready);
endinterface
`default_nettype wire

// ===== sv/scc_rsp_if.sv =====
// scene report channel
`default_nettype none
interface scc_rsp_if;
   logic                  valid;
   logic                  ready;
   logic [1:0]            scene;
   scc_pkg::count_type    road_total;
   scc_pkg::count_type    vehicle_total;
   scc_pkg::count_type    person_total;

   modport source (output valid, output scene, output road_total, output vehicle_total,
                   output person_total, input ready);
   modport sink   (input valid, input scene, input road_total, input vehicle_total,
                   input person_total, output ready);
endinterface
`default_nettype wire

// ===== sv/scc_csr_if.sv =====
// ratio divisor write channel
`default_nettype none
interface scc_csr_if;
   logic                           valid;
   logic                           ready;
   logic [scc_pkg::RATIO_BITS-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/scc_front.sv =====
// pixel counting front end, pushes frame totals at frame end
`default_nettype none
module scc_front (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output      logic                           req_ready,
   input  wire logic [scc_pkg::LABEL_BITS-1:0] req_label,
   input  wire logic                           req_last,
   input  wire logic                           queue_full,
   output      logic                           push,
   output      scc_pkg::frame_type             push_data
);

   scc_pkg::count_type pixel_ff, road_ff, vehicle_ff, person_ff;
   scc_pkg::count_type pixel_in, road_in, vehicle_in, person_in;
   scc_pkg::frame_type step;
   scc_pkg::class_type cls;
   logic               accept;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;
   assign cls       = scc_pkg::classify(req_label);

   always_comb begin
      step.pixel   = scc_pkg::sat_inc(pixel_ff);
      step.road    = (cls == scc_pkg::CLS_ROAD)    ? scc_pkg::sat_inc(road_ff)    : road_ff;
      step.vehicle = (cls == scc_pkg::CLS_VEHICLE) ? scc_pkg::sat_inc(vehicle_ff) : vehicle_ff;
      step.person  = (cls == scc_pkg::CLS_PERSON)  ? scc_pkg::sat_inc(person_ff)  : person_ff;
   end

   always_comb begin
      pixel_in   = pixel_ff;
      road_in    = road_ff;
      vehicle_in = vehicle_ff;
      person_in  = person_ff;
      if (accept) begin
         if (req_last) begin
            pixel_in   = '0;
            road_in    = '0;
            vehicle_in = '0;
            person_in  = '0;
         end else begin
            pixel_in   = step.pixel;
            road_in    = step.road;
            vehicle_in = step.vehicle;
            person_in  = step.person;
         end
      end
   end

   assign push      = accept && req_last;
   assign push_data = step;

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_ff   <= '0;
         road_ff    <= '0;
         vehicle_ff <= '0;
         person_ff  <= '0;
      end else begin
         pixel_ff   <= pixel_in;
         road_ff    <= road_in;
         vehicle_ff <= vehicle_in;
         person_ff  <= person_in;
      end
   end

endmodule
`default_nettype wire

// ===== sv/scc_queue.sv =====
// two-entry queue of frame totals
`default_nettype none
module scc_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire scc_pkg::frame_type push_data,
   input  wire logic               pop,
   output      logic               full,
   output      logic               empty,
   output      scc_pkg::frame_type pop_data
);

   scc_pkg::frame_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;

   assign full     = (fill_ff == 2'd2);
   assign empty    = (fill_ff == 2'd0);
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule
`default_nettype wire

// ===== sv/scc_back.sv =====
// scene decision back end with a bit-serial divider and result register
`default_nettype none
module scc_back (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           queue_empty,
   input  wire scc_pkg::frame_type             frame,
   output      logic                           pop,
   input  wire logic [scc_pkg::RATIO_BITS-1:0] ratio_divisor,
   output      logic                           rsp_valid,
   input  wire logic                           rsp_ready,
   output      logic [1:0]                     rsp_scene,
   output      scc_pkg::count_type             rsp_road_total,
   output      scc_pkg::count_type             rsp_vehicle_total,
   output      scc_pkg::count_type             rsp_person_total
);

   scc_pkg::back_state_type state_ff, state_in;
   scc_pkg::frame_type      frame_ff;
   logic [scc_pkg::RATIO_BITS-1:0] divisor_ff;
   logic [scc_pkg::RATIO_BITS-1:0] rem_d_ff, rem_d_in;
   scc_pkg::count_type             dvd_ff, quo_d_ff, quo_d_in;
   logic [scc_pkg::STEP_BITS-1:0]  step_ff;
   logic [scc_pkg::RATIO_BITS:0]   trial_d;
   logic                           fit_d;
   logic                           load, dividing, emit;
   logic [scc_pkg::COUNT_BITS+1:0] vehicle_x2, person_x3;
   logic [scc_pkg::COUNT_BITS+2:0] road_x5;
   scc_pkg::scene_type             scene;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [1:0]                     scene_ff;
   scc_pkg::count_type             road_ff, vehicle_ff, person_ff;

   // restoring division of the pixel total by the ratio
   always_comb begin
      trial_d  = {rem_d_ff, dvd_ff[scc_pkg::COUNT_BITS-1]};
      fit_d    = trial_d >= {1'b0, divisor_ff};
      rem_d_in = fit_d ? scc_pkg::RATIO_BITS'(trial_d - {1'b0, divisor_ff})
                       : trial_d[scc_pkg::RATIO_BITS-1:0];
      quo_d_in = {quo_d_ff[scc_pkg::COUNT_BITS-2:0], fit_d};
   end

   // road above a fifth of the total is five times road above the total
   always_comb begin
      vehicle_x2 = {1'b0, frame_ff.vehicle, 1'b0};
      person_x3  = {2'b00, frame_ff.person} + {1'b0, frame_ff.person, 1'b0};
      road_x5    = (scc_pkg::COUNT_BITS + 3)'(frame_ff.road)
                 * (scc_pkg::COUNT_BITS + 3)'(scc_pkg::ROAD_SHARE);
      if (frame_ff.vehicle < quo_d_ff && frame_ff.person < quo_d_ff) begin
         scene = (road_x5 > {3'b000, frame_ff.pixel}) ? scc_pkg::SCENE_ROAD
                                                      : scc_pkg::SCENE_UNKNOWN;
      end else begin
         scene = (vehicle_x2 > person_x3) ? scc_pkg::SCENE_CAR : scc_pkg::SCENE_PEOPLE;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         scc_pkg::BACK_IDLE: begin
            if (!queue_empty) state_in = scc_pkg::BACK_DIVIDE;
         end
         scc_pkg::BACK_DIVIDE: begin
            if (step_ff == scc_pkg::STEP_LAST) state_in = scc_pkg::BACK_DECIDE;
         end
         scc_pkg::BACK_DECIDE: begin
            if (!rsp_valid_ff || rsp_ready) state_in = scc_pkg::BACK_IDLE;
         end
         default: state_in = scc_pkg::BACK_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      load     = 1'b0;
      dividing = 1'b0;
      emit     = 1'b0;
      case (state_ff)
         scc_pkg::BACK_IDLE:   load     = !queue_empty;
         scc_pkg::BACK_DIVIDE: dividing = 1'b1;
         scc_pkg::BACK_DECIDE: emit     = !rsp_valid_ff || rsp_ready;
         default: ;
      endcase
   end

   assign pop          = load;
   assign rsp_valid_in = emit || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (load) begin
         frame_ff   <= frame;
         dvd_ff     <= frame.pixel;
         divisor_ff <= (ratio_divisor == '0) ? scc_pkg::RATIO_BITS'(1) : ratio_divisor;
         rem_d_ff   <= '0;
         quo_d_ff   <= '0;
         step_ff    <= '0;
      end else if (dividing) begin
         dvd_ff   <= {dvd_ff[scc_pkg::COUNT_BITS-2:0], 1'b0};
         rem_d_ff <= rem_d_in;
         quo_d_ff <= quo_d_in;
         step_ff  <= step_ff + scc_pkg::STEP_BITS'(1);
      end
      if (emit) begin
         scene_ff   <= scene;
         road_ff    <= frame_ff.road;
         vehicle_ff <= frame_ff.vehicle;
         person_ff  <= frame_ff.person;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= scc_pkg::BACK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_scene         = scene_ff;
   assign rsp_road_total    = road_ff;
   assign rsp_vehicle_total = vehicle_ff;
   assign rsp_person_total  = person_ff;

endmodule
`default_nettype wire

// ===== sv/segmentation_scene_classifier_top.sv =====
// top level of the segmentation scene classifier
//
// req_if carries one pixel label per beat with a last_pixel mark on the final
// pixel of a frame. Labels are taken at one beat per cycle while the queue
// is not full; the front end keeps saturating counts of all, road, vehicle
// and person pixels. At a last pixel the frame totals go into a two-entry
// queue and the counts clear. The back end pops a frame, divides the pixel
// total by the ratio divisor with a bit-serial divider (one bit a cycle),
// compares five times the road count with the pixel total, decides the scene
// and loads the result register on rsp_if.
// The back end takes no new frame until the last one is decided and loaded,
// so short frames back up the queue and req_if.ready drops while it is full.
// A stalled rsp_if holds its result; the back end then waits with the next
// frame decided and the front end keeps counting until the queue fills.
// csr_if writes ratio_divisor (zero acts as one) and is always ready.
// Reset (synchronous) clears counts, queue and result valid and sets the
// ratio divisor to 10.
`default_nettype none
module segmentation_scene_classifier_top (
   input wire logic clock,
   input wire logic reset,
   scc_req_if.sink   req_if,
   scc_rsp_if.source rsp_if,
   scc_csr_if.sink   csr_if
);

   logic [scc_pkg::RATIO_BITS-1:0] ratio_ff, ratio_in;
   logic               push, pop, full, empty;
   scc_pkg::frame_type push_data, pop_data;

   assign csr_if.ready = 1'b1;
   assign ratio_in     = (csr_if.valid && csr_if.ready) ? csr_if.data : ratio_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ratio_ff <= scc_pkg::RATIO_RESET;
      end else begin
         ratio_ff <= ratio_in;
      end
   end

   scc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_if.valid),
      .req_ready  (req_if.ready),
      .req_label  (req_if.label),
      .req_last   (req_if.last_pixel),
      .queue_full (full),
      .push       (push),
      .push_data  (push_data)
   );

   scc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .full      (full),
      .empty     (empty),
      .pop_data  (pop_data)
   );

   scc_back u_back (
      .clock             (clock),
      .reset             (reset),
      .queue_empty       (empty),
      .frame             (pop_data),
      .pop               (pop),
      .ratio_divisor     (ratio_ff),
      .rsp_valid         (rsp_if.valid),
      .rsp_ready         (rsp_if.ready),
      .rsp_scene         (rsp_if.scene),
      .rsp_road_total    (rsp_if.road_total),
      .rsp_vehicle_total (rsp_if.vehicle_total),
      .rsp_person_total  (rsp_if.person_total)
   );

endmodule
`default_nettype wire

// ===== tb/segmentation_scene_classifier_top_tb.sv =====
// self-checking testbench of the segmentation scene classifier top level
`timescale 1ns / 1ps
module segmentation_scene_classifier_top_tb;

   typedef logic [scc_pkg::LABEL_BITS-1:0]   label_type;
   typedef logic [scc_pkg::RATIO_BITS-1:0]   ratio_type;
   typedef logic [scc_pkg::COUNT_BITS+1:0]   wide_type;

   localparam label_type LBL_ROAD       = 8'd0;
   localparam label_type LBL_PERSON     = 8'd11;
   localparam label_type LBL_RIDER      = 8'd12;
   localparam label_type LBL_CAR        = 8'd13;
   localparam label_type LBL_TRUCK      = 8'd14;
   localparam label_type LBL_BUS        = 8'd15;
   localparam label_type LBL_OTHER      = 8'd16;
   localparam label_type LBL_MOTORCYCLE = 8'd17;
   localparam label_type LBL_BICYCLE    = 8'd18;
   localparam label_type LBL_FIRST_FREE = 8'd25;
   localparam int ROAD_PART      = 5;
   localparam int DRAIN_CYCLES   = 30;
   localparam int RANDOM_PIXELS  = 1350;
   localparam int CALM_FROM      = 1150;
   localparam int PHASES         = 6;

   typedef struct packed {
      scc_pkg::scene_type scene;
      scc_pkg::count_type road;
      scc_pkg::count_type vehicle;
      scc_pkg::count_type person;
   } scene_report_type;

   typedef enum logic {ROW_PIXEL, ROW_RATIO} row_kind_type;

   typedef struct packed {
      row_kind_type             kind;
      label_type                label;
      logic                     fin;
      ratio_type                ratio;
      logic                     typed;
      scene_report_type         want;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset;

   always #5 clock = ~clock;

   scc_req_if req_bus ();
   scc_rsp_if rsp_bus ();
   scc_csr_if csr_bus ();

   segmentation_scene_classifier_top DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus),
      .csr_if (csr_bus)
   );

   scc_pkg::count_type    road_cnt, vehicle_cnt, person_cnt, pixel_cnt;
   ratio_type             ratio_reg;
   scene_report_type      pending_reports[$];
   directed_row_type      script[$];

   int unsigned mismatches    = 0;
   int unsigned reports_seen  = 0;
   int unsigned pixels_sent   = 0;
   int unsigned frames_sent   = 0;
   int unsigned ratio_writes  = 0;
   int unsigned scene_hits[4] = '{0, 0, 0, 0};
   int unsigned sink_hold     = 0;
   logic        calm          = 1'b0;

   function automatic scc_pkg::count_type bump(input scc_pkg::count_type v);
      return (v == '1) ? v : v + scc_pkg::count_type'(1);
   endfunction

   task automatic tally_pixel(input label_type lbl, input logic fin,
                              output logic closed, output scene_report_type rep);
      ratio_type             divisor;
      scc_pkg::count_type    bound;
      wide_type              vehicle_x2, person_x3;
      rep = '0;
      pixel_cnt = bump(pixel_cnt);
      case (lbl)
         LBL_ROAD:                                     road_cnt    = bump(road_cnt);
         LBL_CAR, LBL_TRUCK, LBL_BUS, LBL_MOTORCYCLE: vehicle_cnt = bump(vehicle_cnt);
         LBL_PERSON, LBL_RIDER, LBL_BICYCLE:          person_cnt  = bump(person_cnt);
         default: ;
      endcase
      closed = fin;
      if (fin) begin
         divisor = (ratio_reg == '0) ? ratio_type'(1) : ratio_reg;
         bound = pixel_cnt / divisor;
         if (vehicle_cnt < bound && person_cnt < bound) begin
            rep.scene = (road_cnt > pixel_cnt / ROAD_PART) ? scc_pkg::SCENE_ROAD
                                                           : scc_pkg::SCENE_UNKNOWN;
         end else begin
            vehicle_x2 = wide_type'(vehicle_cnt) * wide_type'(2);
            person_x3  = wide_type'(person_cnt) * wide_type'(3);
            rep.scene = (vehicle_x2 > person_x3) ? scc_pkg::SCENE_CAR : scc_pkg::SCENE_PEOPLE;
         end
         rep.road    = road_cnt;
         rep.vehicle = vehicle_cnt;
         rep.person  = person_cnt;
         road_cnt    = '0;
         vehicle_cnt = '0;
         person_cnt  = '0;
         pixel_cnt   = '0;
      end
   endtask

   function automatic directed_row_type pixel_row(input label_type lbl, input logic fin);
      directed_row_type r;
      r = '0;
      r.kind  = ROW_PIXEL;
      r.label = lbl;
      r.fin   = fin;
      return r;
   endfunction

   function automatic directed_row_type checked_row(input label_type lbl,
                                                    input scc_pkg::scene_type s,
                                                    input int unsigned rd,
                                                    input int unsigned vh,
                                                    input int unsigned pr);
      directed_row_type r;
      r = pixel_row(lbl, 1'b1);
      r.typed        = 1'b1;
      r.want.scene   = s;
      r.want.road    = scc_pkg::count_type'(rd);
      r.want.vehicle = scc_pkg::count_type'(vh);
      r.want.person  = scc_pkg::count_type'(pr);
      return r;
   endfunction

   function automatic directed_row_type ratio_row(input ratio_type v);
      directed_row_type r;
      r = '0;
      r.kind  = ROW_RATIO;
      r.ratio = v;
      return r;
   endfunction

   task automatic send_pixel(input label_type lbl, input logic fin,
                             input logic typed, input scene_report_type want);
      logic             closed;
      scene_report_type rep;
      if (!calm && $urandom_range(0, 7) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.label      <= lbl;
      req_bus.last_pixel <= fin;
      do @(posedge clock); while (!req_bus.ready);
      pixels_sent++;
      tally_pixel(lbl, fin, closed, rep);
      if (closed) begin
         if (typed) rep = want;
         pending_reports.push_back(rep);
         frames_sent++;
         scene_hits[rep.scene]++;
      end
   endtask

   task automatic load_ratio(input ratio_type v);
      req_bus.valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.data  <= v;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      ratio_reg = v;
      ratio_writes++;
   endtask

   task automatic send_frame(input int unsigned len);
      int unsigned mix, w_road, w_veh, w_per, pick;
      label_type   lbl;
      mix = $urandom_range(0, 4);
      case (mix)
         0:       begin w_road = 80; w_veh = 2;  w_per = 2;  end
         1:       begin w_road = 20; w_veh = 50; w_per = 15; end
         2:       begin w_road = 20; w_veh = 15; w_per = 50; end
         3:       begin w_road = 5;  w_veh = 2;  w_per = 2;  end
         default: begin w_road = 25; w_veh = 25; w_per = 25; end
      endcase
      for (int unsigned i = 1; i <= len; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < w_road) begin
            lbl = LBL_ROAD;
         end else if (pick < w_road + w_veh) begin
            case ($urandom_range(0, 3))
               0:       lbl = LBL_CAR;
               1:       lbl = LBL_TRUCK;
               2:       lbl = LBL_BUS;
               default: lbl = LBL_MOTORCYCLE;
            endcase
         end else if (pick < w_road + w_veh + w_per) begin
            case ($urandom_range(0, 2))
               0:       lbl = LBL_PERSON;
               1:       lbl = LBL_RIDER;
               default: lbl = LBL_BICYCLE;
            endcase
         end else begin
            lbl = label_type'($urandom_range(1, 255));
         end
         send_pixel(lbl, i == len, 1'b0, '0);
      end
   endtask

   task automatic check_field(input string what, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      end
   endtask

   // scene report checker
   always @(posedge clock) begin
      scene_report_type exp_rep;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_reports.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected report, expected none, actual scene %0d", $time,
                     rsp_bus.scene);
         end else begin
            exp_rep = pending_reports.pop_front();
            reports_seen++;
            check_field("scene", exp_rep.scene, rsp_bus.scene);
            check_field("road_total", exp_rep.road, rsp_bus.road_total);
            check_field("vehicle_total", exp_rep.vehicle, rsp_bus.vehicle_total);
            check_field("person_total", exp_rep.person, rsp_bus.person_total);
         end
      end
   end

   // report sink backpressure
   always @(posedge clock) begin
      if (sink_hold != 0) begin
         sink_hold     <= sink_hold - 1;
         rsp_bus.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
         sink_hold     <= $urandom_range(0, 6);
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   initial begin
      #5_000_000;
      $display("** segmentation_scene_classifier_top: FAILED **");
      $finish;
   end

   initial begin
      int unsigned phase_pixels;
      int unsigned len;
      ratio_type   phase_ratio[PHASES];
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.label      = '0;
      req_bus.last_pixel = 1'b0;
      csr_bus.valid      = 1'b0;
      csr_bus.data       = '0;
      rsp_bus.ready      = 1'b1;
      road_cnt    = '0;
      vehicle_cnt = '0;
      person_cnt  = '0;
      pixel_cnt   = '0;
      ratio_reg   = ratio_type'(10);

      // single pixel frames at the reset divisor
      script.push_back(checked_row(LBL_ROAD, scc_pkg::SCENE_PEOPLE, 1, 0, 0));
      script.push_back(checked_row(LBL_CAR, scc_pkg::SCENE_CAR, 0, 1, 0));
      script.push_back(checked_row(LBL_PERSON, scc_pkg::SCENE_PEOPLE, 0, 0, 1));
      script.push_back(checked_row(8'd255, scc_pkg::SCENE_PEOPLE, 0, 0, 0));
      // the remaining class labels and the edges of the free range in one frame
      script.push_back(pixel_row(LBL_TRUCK, 1'b0));
      script.push_back(pixel_row(LBL_BUS, 1'b0));
      script.push_back(pixel_row(LBL_MOTORCYCLE, 1'b0));
      script.push_back(pixel_row(LBL_RIDER, 1'b0));
      script.push_back(pixel_row(LBL_BICYCLE, 1'b0));
      script.push_back(pixel_row(LBL_OTHER, 1'b0));
      script.push_back(pixel_row(label_type'(LBL_FIRST_FREE - 1), 1'b0));
      script.push_back(pixel_row(LBL_FIRST_FREE, 1'b0));
      script.push_back(pixel_row(8'd10, 1'b1));
      // zero divisor acts as one
      script.push_back(ratio_row(16'd0));
      script.push_back(checked_row(LBL_ROAD, scc_pkg::SCENE_ROAD, 1, 0, 0));
      script.push_back(checked_row(8'd1, scc_pkg::SCENE_UNKNOWN, 0, 0, 0));
      script.push_back(ratio_row(16'hFFFF));
      script.push_back(checked_row(8'd128, scc_pkg::SCENE_PEOPLE, 0, 0, 0));
      script.push_back(checked_row(LBL_MOTORCYCLE, scc_pkg::SCENE_CAR, 0, 1, 0));
      script.push_back(ratio_row(16'd1));
      script.push_back(pixel_row(LBL_ROAD, 1'b0));
      script.push_back(pixel_row(8'd19, 1'b1));
      script.push_back(pixel_row(LBL_RIDER, 1'b0));
      script.push_back(pixel_row(LBL_CAR, 1'b1));

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         if (script[i].kind == ROW_RATIO) begin
            load_ratio(script[i].ratio);
         end else begin
            send_pixel(script[i].label, script[i].fin, script[i].typed, script[i].want);
         end
      end

      phase_ratio[0] = 16'd10;
      phase_ratio[1] = 16'hFFFF;
      phase_ratio[2] = 16'd0;
      phase_ratio[3] = 16'd2;
      phase_ratio[4] = ratio_type'($urandom_range(3, 50));
      phase_ratio[5] = 16'd1;
      phase_pixels = 0;
      for (int p = 0; p < PHASES; p++) begin
         load_ratio(phase_ratio[p]);
         while (phase_pixels < (p + 1) * RANDOM_PIXELS / PHASES) begin
            case ($urandom_range(0, 19))
               0:          len = $urandom_range(61, 300);
               1, 2, 3:    len = $urandom_range(13, 60);
               default:    len = $urandom_range(1, 12);
            endcase
            send_frame(len);
            phase_pixels += len;
            if (phase_pixels >= CALM_FROM) calm <= 1'b1;
         end
      end
      req_bus.valid <= 1'b0;

      while (pending_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d pixels in %0d frames, %0d reports checked, %0d divisor writes",
               pixels_sent, frames_sent, reports_seen, ratio_writes);
      $display("scenes: car %0d, people %0d, road %0d, unknown %0d",
               scene_hits[scc_pkg::SCENE_CAR], scene_hits[scc_pkg::SCENE_PEOPLE],
               scene_hits[scc_pkg::SCENE_ROAD], scene_hits[scc_pkg::SCENE_UNKNOWN]);
      if (mismatches == 0) begin
         $display("** segmentation_scene_classifier_top: PASSED **");
      end else begin
         $display("** segmentation_scene_classifier_top: FAILED **");
      end
      $finish;
   end

endmodule
